>>> src/kmst_pkg.sv
// ----------------------------------------------------------------------------
// kmst_pkg
// Shared types and constants of the minimum spanning tree block.
// ----------------------------------------------------------------------------
package kmst_pkg;

   // field widths
   localparam int VERT_W   = 4;
   localparam int WEIGHT_W = 16;
   localparam int NV_W     = 5;
   localparam int EDGE_W   = 2 * VERT_W + WEIGHT_W;

   // vertex table depth follows the endpoint width
   localparam int MAX_VERTICES = 1 << VERT_W;

   // default edge store depth
   localparam int MAX_EDGES_DEF = 64;

   // reset value of the vertex count register
   localparam logic [NV_W-1:0] NV_RESET = NV_W'(16);

   // run sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIND_A,
      ST_FIND_B,
      ST_END
   } state_type;

   // commands to the union-find unit
   typedef struct packed {
      logic              clear;
      logic              start;
      logic [VERT_W-1:0] node;
      logic              link;
      logic [VERT_W-1:0] link_from;
      logic [VERT_W-1:0] link_to;
   } uf_cmd_type;

   // status from the union-find unit
   typedef struct packed {
      logic              done;
      logic [VERT_W-1:0] root;
   } uf_stat_type;

endpackage

>>> src/kmst_ram.sv
// ----------------------------------------------------------------------------
// kmst_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module kmst_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/kmst_uf.sv
// ----------------------------------------------------------------------------
// kmst_uf
// Union-find unit: parent links with valid bits and a one step per cycle
// root walk.
// ----------------------------------------------------------------------------
module kmst_uf (
   input  logic                 clock,
   input  logic                 reset,
   input  kmst_pkg::uf_cmd_type cmd,
   output kmst_pkg::uf_stat_type stat
);

   logic [kmst_pkg::VERT_W-1:0]     parent_ff [kmst_pkg::MAX_VERTICES];
   logic [kmst_pkg::MAX_VERTICES-1:0] valid_ff;
   logic [kmst_pkg::VERT_W-1:0]     node_ff;
   logic [kmst_pkg::VERT_W-1:0]     root_ff;
   logic                            busy_ff;
   logic                            done_ff;
   logic [kmst_pkg::VERT_W-1:0]     up;

   // an entry never linked is its own root
   always_comb begin
      up = valid_ff[node_ff] ? parent_ff[node_ff] : node_ff;
   end

   // link storage
   always_ff @(posedge clock) begin
      if (cmd.link) begin
         parent_ff[cmd.link_from] <= cmd.link_to;
      end
   end

   // valid bits and root walk
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= !cmd.start && busy_ff && (up == node_ff);
         if (cmd.clear) begin
            valid_ff <= '0;
         end else if (cmd.link) begin
            valid_ff[cmd.link_from] <= 1'b1;
         end
         if (cmd.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && up == node_ff) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // walk position and found root
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         node_ff <= cmd.node;
      end else if (busy_ff) begin
         if (up == node_ff) begin
            root_ff <= node_ff;
         end else begin
            node_ff <= up;
         end
      end
   end

   assign stat.done = done_ff;
   assign stat.root = root_ff;

endmodule

>>> src/kruskal_minimum_spanning_tree_top.sv
// ----------------------------------------------------------------------------
// kruskal_minimum_spanning_tree_top
// Minimum spanning tree by Kruskal's method over a stored edge list.
// ----------------------------------------------------------------------------
// Usage: set num_vertices through the csr_ write channel (always ready) while
// the block is idle. Each request (start high, busy low) loads one edge; an
// edge with an endpoint at or above the vertex count, or beyond the store
// capacity, is dropped. A request with req_last_edge starts the run and busy
// stays high until the run ends.
// The run does one full pass over the edge store per edge plus a closing
// pass, picking the next edge in (weight, arrival) order. Each edge with
// both endpoints in range adds two root walks in the union-find unit, and
// the run ends with a closing state. The single-port read of the edge RAM
// sets the pass length.
// Each selected edge appears on the rsp_ ports for one cycle with rsp_valid;
// the final one carries rsp_last_result. A run that selects nothing gives one
// result with rsp_none_found. The receiver cannot stall the block.
// Reset empties the store and sets the vertex count to 16.
// ----------------------------------------------------------------------------
module kruskal_minimum_spanning_tree_top #(
   parameter int MAX_EDGES = kmst_pkg::MAX_EDGES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [kmst_pkg::VERT_W-1:0]         req_edge_from,
   input  logic [kmst_pkg::VERT_W-1:0]         req_edge_to,
   input  logic signed [kmst_pkg::WEIGHT_W-1:0] req_edge_weight,
   input  logic                                req_last_edge,
   output logic                                rsp_valid,
   output logic [kmst_pkg::VERT_W-1:0]         rsp_tree_from,
   output logic [kmst_pkg::VERT_W-1:0]         rsp_tree_to,
   output logic signed [kmst_pkg::WEIGHT_W-1:0] rsp_tree_weight,
   output logic                                rsp_none_found,
   output logic                                rsp_last_result,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kmst_pkg::NV_W-1:0]           csr_data
);

   localparam int AW = $clog2(MAX_EDGES);
   localparam int CW = $clog2(MAX_EDGES + 1);
   localparam int VW = kmst_pkg::VERT_W;
   localparam int WW = kmst_pkg::WEIGHT_W;
   localparam int NW = kmst_pkg::NV_W;

   kmst_pkg::state_type   state_ff, state_in;
   kmst_pkg::uf_cmd_type  uf_cmd;
   kmst_pkg::uf_stat_type uf_stat;

   logic [NW-1:0]  num_ff;
   logic [NW-1:0]  nv;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  n_ff;
   logic [CW-1:0]  scan_ff;
   logic           rd_vld_ff;
   logic [AW-1:0]  rd_idx_ff;
   logic           found_ff;
   logic [VW-1:0]  best_from_ff, best_to_ff;
   logic signed [WW-1:0] best_w_ff;
   logic [AW-1:0]  best_idx_ff;
   logic           have_last_ff;
   logic signed [WW-1:0] last_w_ff;
   logic [AW-1:0]  last_idx_ff;
   logic           pend_ff;
   logic [VW-1:0]  pend_from_ff, pend_to_ff;
   logic signed [WW-1:0] pend_w_ff;
   logic [VW-1:0]  ra_ff;

   logic           rsp_valid_ff, rsp_none_ff, rsp_last_ff;
   logic [VW-1:0]  rsp_from_ff, rsp_to_ff;
   logic signed [WW-1:0] rsp_w_ff;

   logic                     accept, load_ok, ram_we, ram_re;
   logic [kmst_pkg::EDGE_W-1:0] rd_data;
   logic [VW-1:0]            e_from, e_to;
   logic signed [WW-1:0]     e_w;
   logic                     after_last, better, scan_end, best_ok, differ;

   // vertex count clipped to the table depth
   always_comb begin
      if (num_ff > NW'(kmst_pkg::MAX_VERTICES)) begin
         nv = NW'(kmst_pkg::MAX_VERTICES);
      end else begin
         nv = num_ff;
      end
   end

   // request and load qualification
   assign accept  = start && (state_ff == kmst_pkg::ST_IDLE);
   assign load_ok = ({1'b0, req_edge_from} < nv) && ({1'b0, req_edge_to} < nv)
                    && (count_ff < CW'(MAX_EDGES));

   // edge unpack and scan compares
   assign e_from     = rd_data[kmst_pkg::EDGE_W-1 -: VW];
   assign e_to       = rd_data[WW +: VW];
   assign e_w        = rd_data[WW-1:0];
   assign after_last = !have_last_ff || (e_w > last_w_ff)
                       || ((e_w == last_w_ff) && (rd_idx_ff > last_idx_ff));
   assign better     = !found_ff || (e_w < best_w_ff);
   assign scan_end   = (scan_ff == n_ff) && !rd_vld_ff;
   assign best_ok    = ({1'b0, best_from_ff} < nv) && ({1'b0, best_to_ff} < nv);
   assign differ     = (ra_ff != uf_stat.root);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kmst_pkg::ST_IDLE: begin
            if (accept && req_last_edge) begin
               state_in = kmst_pkg::ST_SCAN;
            end
         end
         kmst_pkg::ST_SCAN: begin
            if (scan_end) begin
               if (!found_ff) begin
                  state_in = kmst_pkg::ST_END;
               end else if (best_ok) begin
                  state_in = kmst_pkg::ST_FIND_A;
               end
            end
         end
         kmst_pkg::ST_FIND_A: begin
            if (uf_stat.done) begin
               state_in = kmst_pkg::ST_FIND_B;
            end
         end
         kmst_pkg::ST_FIND_B: begin
            if (uf_stat.done) begin
               state_in = kmst_pkg::ST_SCAN;
            end
         end
         kmst_pkg::ST_END: begin
            state_in = kmst_pkg::ST_IDLE;
         end
         default: begin
            state_in = kmst_pkg::ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      ram_we           = accept && load_ok;
      ram_re           = 1'b0;
      uf_cmd.clear     = accept && req_last_edge;
      uf_cmd.start     = 1'b0;
      uf_cmd.node      = best_from_ff;
      uf_cmd.link      = 1'b0;
      uf_cmd.link_from = ra_ff;
      uf_cmd.link_to   = uf_stat.root;
      count_in         = count_ff;
      if (ram_we) begin
         count_in = count_ff + CW'(1);
      end
      unique case (state_ff)
         kmst_pkg::ST_IDLE: begin
         end
         kmst_pkg::ST_SCAN: begin
            ram_re       = (scan_ff < n_ff);
            uf_cmd.start = scan_end && found_ff && best_ok;
         end
         kmst_pkg::ST_FIND_A: begin
            uf_cmd.start = uf_stat.done;
            uf_cmd.node  = best_to_ff;
         end
         kmst_pkg::ST_FIND_B: begin
            uf_cmd.link = uf_stat.done && differ;
         end
         kmst_pkg::ST_END: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kmst_pkg::ST_IDLE;
         num_ff       <= kmst_pkg::NV_RESET;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         have_last_ff <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= ram_re;
         rsp_valid_ff <= ((state_ff == kmst_pkg::ST_FIND_B) && uf_stat.done && differ
                          && pend_ff) || (state_ff == kmst_pkg::ST_END);
         if (csr_valid) begin
            num_ff <= csr_data;
         end
         if (accept && req_last_edge) begin
            found_ff     <= 1'b0;
            have_last_ff <= 1'b0;
            pend_ff      <= 1'b0;
         end
         if (state_ff == kmst_pkg::ST_SCAN) begin
            if (rd_vld_ff && after_last && better) begin
               found_ff <= 1'b1;
            end
            if (scan_end && found_ff) begin
               have_last_ff <= 1'b1;
               found_ff     <= 1'b0;
            end
         end
         if (state_ff == kmst_pkg::ST_FIND_B && uf_stat.done && differ) begin
            pend_ff <= 1'b1;
         end
      end
   end

   // scan and result datapath
   always_ff @(posedge clock) begin
      if (accept && req_last_edge) begin
         n_ff    <= count_in;
         scan_ff <= '0;
      end
      rd_idx_ff <= scan_ff[AW-1:0];
      if (ram_re) begin
         scan_ff <= scan_ff + CW'(1);
      end
      if (state_ff == kmst_pkg::ST_SCAN) begin
         if (rd_vld_ff && after_last && better) begin
            best_from_ff <= e_from;
            best_to_ff   <= e_to;
            best_w_ff    <= e_w;
            best_idx_ff  <= rd_idx_ff;
         end
         if (scan_end && found_ff) begin
            last_w_ff   <= best_w_ff;
            last_idx_ff <= best_idx_ff;
            scan_ff     <= '0;
         end
      end
      if (state_ff == kmst_pkg::ST_FIND_A && uf_stat.done) begin
         ra_ff <= uf_stat.root;
      end
      if (state_ff == kmst_pkg::ST_FIND_B && uf_stat.done && differ) begin
         pend_from_ff <= best_from_ff;
         pend_to_ff   <= best_to_ff;
         pend_w_ff    <= best_w_ff;
         rsp_from_ff  <= pend_from_ff;
         rsp_to_ff    <= pend_to_ff;
         rsp_w_ff     <= pend_w_ff;
         rsp_none_ff  <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end
      if (state_ff == kmst_pkg::ST_END) begin
         rsp_last_ff <= 1'b1;
         if (pend_ff) begin
            rsp_from_ff <= pend_from_ff;
            rsp_to_ff   <= pend_to_ff;
            rsp_w_ff    <= pend_w_ff;
            rsp_none_ff <= 1'b0;
         end else begin
            rsp_from_ff <= '0;
            rsp_to_ff   <= '0;
            rsp_w_ff    <= '0;
            rsp_none_ff <= 1'b1;
         end
      end
   end

   // edge store
   kmst_ram #(
      .WIDTH (kmst_pkg::EDGE_W),
      .DEPTH (MAX_EDGES)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({req_edge_from, req_edge_to, req_edge_weight}),
      .rd_en   (ram_re),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // union-find unit
   kmst_uf u_uf (
      .clock (clock),
      .reset (reset),
      .cmd   (uf_cmd),
      .stat  (uf_stat)
   );

   assign busy            = (state_ff != kmst_pkg::ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tree_from   = rsp_from_ff;
   assign rsp_tree_to     = rsp_to_ff;
   assign rsp_tree_weight = rsp_w_ff;
   assign rsp_none_found  = rsp_none_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

>>> verif/kruskal_minimum_spanning_tree_top_tb.sv
// ----------------------------------------------------------------------------
// kruskal_minimum_spanning_tree_top_tb
// Self-checking bench for the minimum spanning tree block: loads edge lists,
// predicts the selected tree edges in order and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module kruskal_minimum_spanning_tree_top_tb;

   localparam int N_EDGES      = 64;
   localparam int VERT_W       = kmst_pkg::VERT_W;
   localparam int WEIGHT_W     = kmst_pkg::WEIGHT_W;
   localparam int NV_W         = kmst_pkg::NV_W;
   localparam int MAX_VERTICES = kmst_pkg::MAX_VERTICES;

   typedef struct packed {
      logic [VERT_W-1:0]          from;
      logic [VERT_W-1:0]          to;
      logic signed [WEIGHT_W-1:0] weight;
   } edge_type;

   typedef struct packed {
      logic [VERT_W-1:0]          from;
      logic [VERT_W-1:0]          to;
      logic signed [WEIGHT_W-1:0] weight;
      logic                       none;
      logic                       last;
   } tree_edge_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [VERT_W-1:0] req_edge_from = '0;
   logic [VERT_W-1:0] req_edge_to = '0;
   logic signed [WEIGHT_W-1:0] req_edge_weight = '0;
   logic req_last_edge = 0;
   logic rsp_valid;
   logic [VERT_W-1:0] rsp_tree_from;
   logic [VERT_W-1:0] rsp_tree_to;
   logic signed [WEIGHT_W-1:0] rsp_tree_weight;
   logic rsp_none_found;
   logic rsp_last_result;
   logic csr_valid = 0;
   logic csr_ready;
   logic [NV_W-1:0] csr_data = '0;

   // predictor state
   edge_type        graph_edges[N_EDGES];
   int              graph_count;
   int              root_links[MAX_VERTICES];
   logic [NV_W-1:0] vertex_count;
   tree_edge_type   expected_tree[$];
   int              mismatch_count;
   int              request_count;
   int              run_count;
   int              result_count;

   kruskal_minimum_spanning_tree_top #(.MAX_EDGES(N_EDGES)) dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // root walk over the predicted parent links, bounded to MAX_VERTICES steps
   function automatic int root_of(input int node);
      for (int s = 0; s < MAX_VERTICES; s++) begin
         if (root_links[node] == node) break;
         node = root_links[node];
      end
      return node;
   endfunction

   // compute the tree edges of one run from the stored graph
   task automatic build_tree();
      int nv;
      int ra, rb;
      int picked;
      edge_type hold;
      int j;
      tree_edge_type t;
      nv = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : vertex_count;
      picked = 0;
      for (int i = 1; i < graph_count; i++) begin
         hold = graph_edges[i];
         j = i;
         while (j > 0 && graph_edges[j-1].weight > hold.weight) begin
            graph_edges[j] = graph_edges[j-1];
            j--;
         end
         graph_edges[j] = hold;
      end
      for (int i = 0; i < MAX_VERTICES; i++) root_links[i] = i;
      for (int i = 0; i < graph_count; i++) begin
         if (graph_edges[i].from >= nv || graph_edges[i].to >= nv) continue;
         ra = root_of(graph_edges[i].from);
         rb = root_of(graph_edges[i].to);
         if (ra != rb && picked < 15) begin
            t = '{graph_edges[i].from, graph_edges[i].to, graph_edges[i].weight, 1'b0, 1'b0};
            expected_tree = {expected_tree, t};
            root_links[ra] = rb;
            picked++;
         end
      end
      graph_count = 0;
      if (picked == 0) begin
         t = '{'0, '0, '0, 1'b1, 1'b1};
         expected_tree = {expected_tree, t};
      end else begin
         expected_tree[expected_tree.size()-1].last = 1'b1;
      end
   endtask

   // send one edge request and update the prediction
   task automatic send_edge(input int f, input int t, input int w, input bit last);
      int nv;
      int gap;
      gap = $urandom_range(0, 5);
      // idle gap before the request
      if (gap != 0) begin
         start <= 0;
         repeat (gap) @(negedge clock);
      end
      start <= 1;
      req_edge_from <= f[VERT_W-1:0];
      req_edge_to <= t[VERT_W-1:0];
      req_edge_weight <= w[WEIGHT_W-1:0];
      req_last_edge <= last;
      // taken at the first rising edge with busy low
      while (busy) @(negedge clock);
      @(posedge clock);
      nv = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : vertex_count;
      if (f < nv && t < nv && graph_count < N_EDGES) begin
         graph_edges[graph_count] = '{f[VERT_W-1:0], t[VERT_W-1:0], w[WEIGHT_W-1:0]};
         graph_count++;
      end
      request_count++;
      if (last) begin
         build_tree();
         run_count++;
      end
      @(negedge clock);
   endtask

   // wait until every predicted result has arrived, then let the block settle
   task automatic drain();
      int guard;
      guard = 0;
      start <= 0;
      while (expected_tree.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (20) @(negedge clock);
   endtask

   task automatic write_vertex_count(input int nv);
      drain();
      csr_valid <= 1;
      csr_data <= nv[NV_W-1:0];
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      vertex_count = nv[NV_W-1:0];
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // result checker
   always @(posedge clock) begin
      tree_edge_type want;
      if (!reset && rsp_valid) begin
         result_count++;
         if (expected_tree.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result from %0d to %0d",
               rsp_tree_from, rsp_tree_to);
         end else begin
            want = expected_tree.pop_front();
            if (rsp_tree_from !== want.from || rsp_tree_to !== want.to ||
                rsp_tree_weight !== want.weight || rsp_none_found !== want.none ||
                rsp_last_result !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp %0d-%0d w%0d n%0b l%0b got %0d-%0d w%0d n%0b l%0b",
                     want.from, want.to, want.weight, want.none, want.last,
                     rsp_tree_from, rsp_tree_to, rsp_tree_weight, rsp_none_found,
                     rsp_last_result);
            end
         end
      end
   end

   // random graph with endpoints drawn from 0 to span
   task automatic send_random_graph(input int n_edges, input int span);
      for (int i = 0; i < n_edges; i++)
         send_edge($urandom_range(0, span), $urandom_range(0, span),
            ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 65535),
            i == n_edges - 1);
   endtask

   task automatic test_extremes();
      send_edge(0, 15, -32768, 0);
      send_edge(15, 0, 32767, 0);
      send_edge(3, 3, 0, 0);
      send_edge(1, 2, 5, 0);
      send_edge(2, 1, 5, 0);
      send_edge(4, 5, -1, 1);
      // a lone self loop gives none found
      send_edge(7, 7, 9, 1);
   endtask

   task automatic test_vertex_limits();
      write_vertex_count(1);
      send_edge(0, 0, 1, 0);
      send_edge(0, 1, 2, 1);
      write_vertex_count(0);
      send_edge(0, 0, 3, 1);
      write_vertex_count(31);
      send_edge(14, 15, 4, 0);
      send_edge(0, 14, 4, 1);
      write_vertex_count(4);
      send_edge(1, 2, 7, 0);
      send_edge(3, 9, 1, 1);
      write_vertex_count(16);
   endtask

   // endpoints stored then run after lowering the vertex count
   task automatic test_lowered_count();
      send_edge(1, 12, 1, 0);
      send_edge(0, 1, 2, 0);
      drain();
      write_vertex_count(8);
      send_edge(2, 3, 3, 1);
      write_vertex_count(16);
   endtask

   task automatic test_store_full();
      for (int i = 0; i < 70; i++)
         send_edge($urandom_range(0, 15), $urandom_range(0, 15),
            $urandom_range(0, 65535), i == 69);
   endtask

   task automatic test_random();
      int nv;
      while (request_count < 480) begin
         if ($urandom_range(0, 7) == 0) begin
            nv = $urandom_range(0, 17);
            write_vertex_count(nv == 17 ? 16 : nv);
         end
         if ($urandom_range(0, 9) == 0) drain();
         send_random_graph($urandom_range(1, 20), 15);
      end
   endtask

   initial begin
      graph_count = 0;
      vertex_count = kmst_pkg::NV_RESET;
      mismatch_count = 0;
      request_count = 0;
      run_count = 0;
      result_count = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_extremes();
      test_vertex_limits();
      test_lowered_count();
      test_store_full();
      test_random();
      drain();
      $display("covered %0d edge requests in %0d runs, %0d results checked",
         request_count, run_count, result_count);
      if (mismatch_count == 0 && expected_tree.size() == 0)
         $display("kruskal_minimum_spanning_tree_top_tb passed");
      else
         $display("kruskal_minimum_spanning_tree_top_tb failed");
      $finish;
   end

   // run time limit
   initial begin
      #20ms;
      $display("kruskal_minimum_spanning_tree_top_tb failed");
      $finish;
   end

endmodule

>>> kruskal_minimum_spanning_tree_top.f
src/kmst_pkg.sv
src/kmst_ram.sv
src/kmst_uf.sv
src/kruskal_minimum_spanning_tree_top.sv
verif/kruskal_minimum_spanning_tree_top_tb.sv
